[sv/sva_pkg.sv]
`timescale 1ns / 1ps

package sva_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HANDLE_W = 32;

	typedef enum logic [2:0] {
		KIND_PLAY     = 3'd0,
		KIND_STOP     = 3'd1,
		KIND_PAUSE    = 3'd2,
		KIND_RESUME   = 3'd3,
		KIND_QUERY    = 3'd4,
		KIND_FINISHED = 3'd5,
		KIND_STOP_ALL = 3'd6,
		KIND_UNUSED   = 3'd7
	} kind_t;

	localparam logic [1:0] ST_STOPPED = 2'd0;
	localparam logic [1:0] ST_PLAYING = 2'd1;
	localparam logic [1:0] ST_PAUSED  = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} sva_cmd_t;

	typedef struct packed {
		logic scan_req;
		logic scan_last;
		logic out_free;
	} sva_status_t;

endpackage

[sv/sva_datapath.sv]
`timescale 1ns / 1ps

module sva_datapath import sva_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  sva_cmd_t            cmd,
	output sva_status_t         status,
	input  logic [2:0]          kind,
	input  logic [7:0]          sound_id,
	input  logic                loop_request,
	input  logic [HANDLE_W-1:0] target_handle,
	input  logic [2:0]          done_channel,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HANDLE_W-1:0] new_handle,
	output logic [2:0]          chosen_channel,
	output logic                stole,
	output logic [HANDLE_W-1:0] evicted_handle,
	output logic                found,
	output logic [1:0]          sound_state
);

	// channel table
	logic [HANDLE_W-1:0] handle_q  [CHANNELS];
	logic [7:0]          sound_q   [CHANNELS];
	logic                looping_q [CHANNELS];
	logic                paused_q  [CHANNELS];
	logic [HANDLE_W-1:0] cnt_q;

	// latched item
	kind_t               kind_q;
	logic [7:0]          snd_q;
	logic                loop_q;
	logic [HANDLE_W-1:0] tgt_q;
	logic [2:0]          done_q;

	// scan state
	logic [CH_W-1:0]     idx_q;
	logic                free_v_q, same_v_q, nl_v_q, hit_v_q, hit_p_q, done_occ_q;
	logic [CH_W-1:0]     free_i_q, same_i_q, nl_i_q, old_i_q, hit_i_q;
	logic [HANDLE_W-1:0] same_h_q, nl_h_q, old_h_q;

	// result register
	logic                out_valid_q;
	logic [HANDLE_W-1:0] out_new_q, out_evict_q;
	logic [2:0]          out_chan_q;
	logic                out_stole_q, out_found_q;
	logic [1:0]          out_state_q;

	logic [HANDLE_W-1:0] cur_h;
	logic [7:0]          cur_snd;
	logic                cur_loop, cur_pause;
	logic [CH_W-1:0]     play_i, done_i;
	logic [HANDLE_W-1:0] play_evict, next_cnt;
	logic [HANDLE_W-1:0] res_new, res_evict;
	logic [2:0]          res_chan;
	logic                res_stole, res_found;
	logic [1:0]          res_state;

	assign cur_h     = handle_q[idx_q];
	assign cur_snd   = sound_q[idx_q];
	assign cur_loop  = looping_q[idx_q];
	assign cur_pause = paused_q[idx_q];

	always_comb begin
		status.scan_req  = (kind_t'(kind) inside {KIND_PLAY, KIND_STOP, KIND_PAUSE,
			KIND_RESUME, KIND_QUERY, KIND_FINISHED});
		status.scan_last = (idx_q == CH_W'(CHANNELS - 1));
		status.out_free  = !out_valid_q || !out_stall;
	end

	// steal order: free, newest same sound, newest non-looping, oldest
	always_comb begin
		if (free_v_q) begin
			play_i     = free_i_q;
			play_evict = '0;
		end else if (same_v_q) begin
			play_i     = same_i_q;
			play_evict = same_h_q;
		end else if (nl_v_q) begin
			play_i     = nl_i_q;
			play_evict = nl_h_q;
		end else begin
			play_i     = old_i_q;
			play_evict = old_h_q;
		end
	end

	// counter skips zero on wrap
	assign next_cnt = (cnt_q == '1) ? HANDLE_W'(1) : cnt_q + HANDLE_W'(1);
	assign done_i   = CH_W'(done_q);

	always_comb begin
		res_new   = '0;
		res_evict = '0;
		res_chan  = '0;
		res_stole = 1'b0;
		res_found = 1'b0;
		res_state = ST_STOPPED;
		case (kind_q)
			KIND_PLAY: begin
				res_new   = next_cnt;
				res_chan  = 3'(play_i);
				res_stole = !free_v_q;
				res_evict = play_evict;
			end
			KIND_STOP, KIND_PAUSE, KIND_RESUME, KIND_QUERY: begin
				res_found = hit_v_q;
				res_chan  = hit_v_q ? 3'(hit_i_q) : 3'd0;
				if (kind_q == KIND_QUERY && hit_v_q)
					res_state = hit_p_q ? ST_PAUSED : ST_PLAYING;
			end
			KIND_FINISHED: begin
				res_chan  = done_q;
				res_found = done_occ_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++)
				handle_q[i] <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				case (kind_q)
					KIND_PLAY: begin
						handle_q[play_i] <= next_cnt;
						cnt_q            <= next_cnt;
					end
					KIND_STOP: begin
						if (hit_v_q)
							handle_q[hit_i_q] <= '0;
					end
					KIND_FINISHED: begin
						if (done_occ_q)
							handle_q[done_i] <= '0;
					end
					KIND_STOP_ALL: begin
						for (int i = 0; i < CHANNELS; i++)
							handle_q[i] <= '0;
					end
					default: begin
					end
				endcase
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind_t'(kind);
			snd_q      <= sound_id;
			loop_q     <= loop_request;
			tgt_q      <= target_handle;
			done_q     <= done_channel;
			idx_q      <= '0;
			free_v_q   <= 1'b0;
			same_v_q   <= 1'b0;
			nl_v_q     <= 1'b0;
			hit_v_q    <= 1'b0;
			done_occ_q <= 1'b0;
		end
		if (cmd.step) begin
			idx_q <= idx_q + CH_W'(1);
			if (!free_v_q && cur_h == '0) begin
				free_v_q <= 1'b1;
				free_i_q <= idx_q;
			end
			if (cur_h != '0 && cur_snd == snd_q && (!same_v_q || cur_h > same_h_q)) begin
				same_v_q <= 1'b1;
				same_i_q <= idx_q;
				same_h_q <= cur_h;
			end
			if (cur_h != '0 && !cur_loop && (!nl_v_q || cur_h > nl_h_q)) begin
				nl_v_q <= 1'b1;
				nl_i_q <= idx_q;
				nl_h_q <= cur_h;
			end
			if (idx_q == '0 || cur_h < old_h_q) begin
				old_i_q <= idx_q;
				old_h_q <= cur_h;
			end
			if (!hit_v_q && tgt_q != '0 && cur_h == tgt_q) begin
				hit_v_q <= 1'b1;
				hit_i_q <= idx_q;
				hit_p_q <= cur_pause;
			end
			if (int'(done_q) == int'(idx_q) && cur_h != '0)
				done_occ_q <= 1'b1;
		end
		if (cmd.commit) begin
			case (kind_q)
				KIND_PLAY: begin
					sound_q[play_i]   <= snd_q;
					looping_q[play_i] <= loop_q;
					paused_q[play_i]  <= 1'b0;
				end
				KIND_PAUSE: begin
					if (hit_v_q)
						paused_q[hit_i_q] <= 1'b1;
				end
				KIND_RESUME: begin
					if (hit_v_q)
						paused_q[hit_i_q] <= 1'b0;
				end
				default: begin
				end
			endcase
			out_new_q   <= res_new;
			out_evict_q <= res_evict;
			out_chan_q  <= res_chan;
			out_stole_q <= res_stole;
			out_found_q <= res_found;
			out_state_q <= res_state;
		end
	end

	assign out_valid      = out_valid_q;
	assign new_handle     = out_new_q;
	assign chosen_channel = out_chan_q;
	assign stole          = out_stole_q;
	assign evicted_handle = out_evict_q;
	assign found          = out_found_q;
	assign sound_state    = out_state_q;

`ifndef NO_ASSERTIONS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while still waiting");
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && kind_q == KIND_PLAY) |=> (cnt_q != '0 && out_new_q == cnt_q))
		else $error("play issued handle zero or mismatched counter");
	a_steal_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stole_q) |-> (out_evict_q != '0 && out_new_q != '0))
		else $error("steal reported without an evicted handle");
`endif

endmodule

[sv/sva_ctrl.sv]
`timescale 1ns / 1ps

module sva_ctrl import sva_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  sva_status_t status,
	output sva_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.scan_req ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (status.scan_last)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && status.scan_last) |=> state_q == S_FINISH)
		else $error("scan did not end after last channel");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SCAN || state_q == S_FINISH))
		else $error("item taken without starting work");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.commit}))
		else $error("conflicting datapath commands");
`endif

endmodule

[sv/sound_voice_allocator.sv]
`timescale 1ns / 1ps

// sound voice allocator: a table of 8 channels, each holding a handle, sound id,
// looping and paused marks. play takes the lowest free channel, or else steals
// the newest handle of the same sound, then the newest non-looping handle, then
// the oldest handle; every play issues the next nonzero handle. stop, pause,
// resume, query, channel-finished and stop-all are also handled, one result item
// per input item. kinds 0 to 5 walk the table one channel per cycle, then the
// result is registered; stop-all and the unused kind go straight to the result.
// one item is worked at a time; the result sits in an output register, so the
// next item is taken while it waits to be collected.
module sound_voice_allocator import sva_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          kind,
	input  logic [7:0]          sound_id,
	input  logic                loop_request,
	input  logic [HANDLE_W-1:0] target_handle,
	input  logic [2:0]          done_channel,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HANDLE_W-1:0] new_handle,
	output logic [2:0]          chosen_channel,
	output logic                stole,
	output logic [HANDLE_W-1:0] evicted_handle,
	output logic                found,
	output logic [1:0]          sound_state
);

	sva_cmd_t    cmd;
	sva_status_t status;

	sva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sva_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.kind           (kind),
		.sound_id       (sound_id),
		.loop_request   (loop_request),
		.target_handle  (target_handle),
		.done_channel   (done_channel),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.new_handle     (new_handle),
		.chosen_channel (chosen_channel),
		.stole          (stole),
		.evicted_handle (evicted_handle),
		.found          (found),
		.sound_state    (sound_state)
	);

endmodule
